[rtl/core/pinhole_primary_ray_direction_assert.svh]
// ----------------------------------------------------------------------------
// Pinhole primary ray direction: assertion macros.
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_PRIMARY_RAY_DIRECTION_ASSERT_SVH
`define PINHOLE_PRIMARY_RAY_DIRECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define PPRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pprd check failed");
`define PPRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pprd check failed");
`else
`define PPRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PPRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/pprd_pkg.sv]
// ----------------------------------------------------------------------------
// Pinhole primary ray direction: package.
// Widths, register codes, transaction types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package pprd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 20;
    localparam int COMP_BITS  = FRAC_BITS + 1;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int REG_BITS   = 63;
    localparam int EXT_BITS   = REG_BITS + 3 * COMP_BITS;
    localparam int U_BITS     = COORD_BITS + 2;
    localparam int PROD_BITS  = U_BITS + COMP_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int POS_BITS   = $clog2(SUM_BITS);
    localparam int NORM_MSB   = 29;
    localparam int NMAG_BITS  = NORM_MSB + 1;
    localparam int SQ_BITS    = 2 * NMAG_BITS;
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_W     = 2 * ROOT_STEPS;
    localparam int ROOT_BITS  = NMAG_BITS + 1;
    localparam int OUT_FRAC   = 14;
    localparam int OUT_BITS   = 16;
    localparam int QUO_BITS   = OUT_FRAC + 1;
    localparam int NUM_BITS   = NMAG_BITS + OUT_FRAC + 1;
    localparam int OUT_ONE    = 1 << OUT_FRAC;

    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_LSB   = 3;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    typedef enum logic [2:0] {
        REG_STEP_RIGHT   = 3'd0,
        REG_STEP_DOWN    = 3'd1,
        REG_VIEW_AXIS    = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_col;
        logic [COORD_BITS-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] dir_x;
        logic signed [OUT_BITS-1:0] dir_y;
        logic signed [OUT_BITS-1:0] dir_z;
    } t_dir;

    typedef struct packed {
        logic [REG_BITS-1:0]  step_right;
        logic [REG_BITS-1:0]  step_down;
        logic [REG_BITS-1:0]  view_axis;
        logic [SIZE_BITS-1:0] image_width;
        logic [SIZE_BITS-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [2:0][SUM_BITS-1:0] mag;
        logic [2:0]               neg;
    } t_front_item;

    typedef struct packed {
        logic [2:0][NMAG_BITS-1:0] mag;
        logic [2:0]                neg;
        logic                      zero;
    } t_carry;

    // Components that lie partly or wholly above the register read as zero there.
    function automatic logic signed [COMP_BITS-1:0] get_comp(
        input logic [REG_BITS-1:0] reg_v,
        input int                  k
    );
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(reg_v);
        return ext[k*COMP_BITS +: COMP_BITS];
    endfunction

endpackage
`default_nettype wire

[rtl/core/pprd_cfg.sv]
// ----------------------------------------------------------------------------
// Pinhole primary ray direction: configuration registers.
// APB register file for the step vectors, viewing axis and image size.
// ----------------------------------------------------------------------------
`default_nettype none
module pprd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pprd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [pprd_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [pprd_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output pprd_pkg::t_cfg                      o_cfg
);
    import pprd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[CFG_ADDR_BITS-1:CFG_IDX_LSB]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_right   <= '0;
            r_cfg.step_down    <= '0;
            r_cfg.view_axis    <= '0;
            r_cfg.image_width  <= SIZE_BITS'(WIDTH_RESET);
            r_cfg.image_height <= SIZE_BITS'(HEIGHT_RESET);
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_STEP_RIGHT:   r_cfg.step_right   <= pwdata[REG_BITS-1:0];
                REG_STEP_DOWN:    r_cfg.step_down    <= pwdata[REG_BITS-1:0];
                REG_VIEW_AXIS:    r_cfg.view_axis    <= pwdata[REG_BITS-1:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_STEP_RIGHT:   prdata = CFG_DATA_BITS'(r_cfg.step_right);
            REG_STEP_DOWN:    prdata = CFG_DATA_BITS'(r_cfg.step_down);
            REG_VIEW_AXIS:    prdata = CFG_DATA_BITS'(r_cfg.view_axis);
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_BITS'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_BITS'(r_cfg.image_height);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/pprd_front.sv]
// ----------------------------------------------------------------------------
// Pinhole primary ray direction: front end.
// Accepts pixels and forms the signed direction components and magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none
module pprd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pprd_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  pprd_pkg::t_pixel      i_pixel,
    output logic                  o_valid,
    input  logic                  i_full,
    output pprd_pkg::t_front_item o_item
);
    import pprd_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3;
    logic signed [U_BITS-1:0]    r_u, r_v;
    logic signed [U_BITS-1:0]    n_u, n_v;
    logic signed [PROD_BITS-1:0] r_pr [3];
    logic signed [PROD_BITS-1:0] r_pd [3];
    t_front_item                 r_item, n_item;

    assign en      = !(r_v3 && i_full);
    assign o_stall = !en;
    assign o_valid = r_v3;
    assign o_item  = r_item;

    assign n_u = $signed({1'b0, i_pixel.pixel_col, 1'b1}) - $signed({1'b0, i_cfg.image_width});
    assign n_v = $signed({1'b0, i_pixel.pixel_row, 1'b1}) - $signed({1'b0, i_cfg.image_height});

    always_comb begin
        logic signed [SUM_BITS-1:0] c;
        n_item = '0;
        for (int k = 0; k < 3; k++) begin
            c = SUM_BITS'(r_pr[k]) + SUM_BITS'(r_pd[k])
                + (SUM_BITS'(get_comp(i_cfg.view_axis, k)) <<< 1);
            n_item.neg[k] = c[SUM_BITS-1];
            n_item.mag[k] = c[SUM_BITS-1] ? SUM_BITS'(-c) : SUM_BITS'(c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u <= n_u;
            r_v <= n_v;
            for (int k = 0; k < 3; k++) begin
                r_pr[k] <= PROD_BITS'(r_u) * PROD_BITS'(get_comp(i_cfg.step_right, k));
                r_pd[k] <= PROD_BITS'(r_v) * PROD_BITS'(get_comp(i_cfg.step_down, k));
            end
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

[rtl/core/pprd_fifo.sv]
// ----------------------------------------------------------------------------
// Pinhole primary ray direction: decoupling queue.
// Short queue between the front end and the normalizing back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pprd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_full,
    input  pprd_pkg::t_front_item i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pprd_pkg::t_front_item o_item
);
    import pprd_pkg::*;

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_front_item         r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_BITS-1:0] r_cnt;
    logic                push, pop;

    assign o_full  = (r_cnt == CNT_BITS'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && !o_full;
    assign pop     = o_valid && !i_stall;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/pprd_back.sv]
// ----------------------------------------------------------------------------
// Pinhole primary ray direction: back end.
// Normalizes, takes the integer square root and divides, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none
module pprd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  pprd_pkg::t_front_item i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pprd_pkg::t_dir        o_dir
);
    import pprd_pkg::*;

    localparam int LAT = 5 + ROOT_STEPS + 1 + QUO_BITS + 1;

    logic           en;
    logic [LAT-1:0] r_vld;

    logic [2:0][SUM_BITS-1:0] r_b1_mag, r_b2_mag;
    logic [2:0]               r_b1_neg, r_b2_neg;
    logic [SUM_BITS-1:0]      r_b1_max, n_max;
    logic [POS_BITS-1:0]      r_b2_pos, n_pos;
    logic                     r_b2_zero;
    t_carry                   r_b3_c, n_b3_c, r_b4_c;
    logic [2:0][SQ_BITS-1:0]  r_b4_sq;

    logic [ROOT_W-1:0] r_rs   [ROOT_STEPS+1];
    logic [ROOT_W-1:0] r_rres [ROOT_STEPS+1];
    t_carry            r_rc   [ROOT_STEPS+1];

    logic [2:0][NUM_BITS-1:0] r_rem [QUO_BITS+1];
    logic [2:0][QUO_BITS-1:0] r_quo [QUO_BITS+1];
    logic [ROOT_BITS-1:0]     r_drt [QUO_BITS+1];
    t_carry                   r_dc  [QUO_BITS+1];
    logic [ROOT_BITS-1:0]     root;

    t_dir r_dir, n_dir;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];
    assign o_dir   = r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_comb begin
        n_max = i_item.mag[0];
        if (i_item.mag[1] > n_max) begin
            n_max = i_item.mag[1];
        end
        if (i_item.mag[2] > n_max) begin
            n_max = i_item.mag[2];
        end
    end

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < SUM_BITS; b++) begin
            if (r_b1_max[b]) begin
                n_pos = POS_BITS'(b);
            end
        end
    end

    always_comb begin
        logic [SUM_BITS-1:0] sh;
        n_b3_c.neg  = r_b2_neg;
        n_b3_c.zero = r_b2_zero;
        for (int k = 0; k < 3; k++) begin
            if (r_b2_pos > POS_BITS'(NORM_MSB)) begin
                sh = r_b2_mag[k] >> (r_b2_pos - POS_BITS'(NORM_MSB));
            end else begin
                sh = r_b2_mag[k] << (POS_BITS'(NORM_MSB) - r_b2_pos);
            end
            n_b3_c.mag[k] = sh[NMAG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_mag  <= i_item.mag;
            r_b1_neg  <= i_item.neg;
            r_b1_max  <= n_max;
            r_b2_mag  <= r_b1_mag;
            r_b2_neg  <= r_b1_neg;
            r_b2_pos  <= n_pos;
            r_b2_zero <= (r_b1_max == '0);
            r_b3_c    <= n_b3_c;
            for (int k = 0; k < 3; k++) begin
                r_b4_sq[k] <= SQ_BITS'(r_b3_c.mag[k]) * SQ_BITS'(r_b3_c.mag[k]);
            end
            r_b4_c    <= r_b3_c;
            r_rs[0]   <= ROOT_W'(r_b4_sq[0]) + ROOT_W'(r_b4_sq[1]) + ROOT_W'(r_b4_sq[2]);
            r_rres[0] <= '0;
            r_rc[0]   <= r_b4_c;
        end
    end

    for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
        logic [ROOT_W-1:0] bitv, trial;
        assign bitv  = ROOT_W'(1) << (ROOT_W - 2 - 2 * i);
        assign trial = r_rres[i] + bitv;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_rs[i] >= trial) begin
                    r_rs[i+1]   <= r_rs[i] - trial;
                    r_rres[i+1] <= (r_rres[i] >> 1) + bitv;
                end else begin
                    r_rs[i+1]   <= r_rs[i];
                    r_rres[i+1] <= r_rres[i] >> 1;
                end
                r_rc[i+1] <= r_rc[i];
            end
        end
    end

    assign root = r_rres[ROOT_STEPS][ROOT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= (NUM_BITS'(r_rc[ROOT_STEPS].mag[k]) << OUT_FRAC)
                               + NUM_BITS'(root >> 1);
            end
            r_quo[0] <= '0;
            r_drt[0] <= root;
            r_dc[0]  <= r_rc[ROOT_STEPS];
        end
    end

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
        logic [NUM_BITS-1:0] dsh;
        assign dsh = NUM_BITS'(r_drt[j]) << (QUO_BITS - 1 - j);
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[j][k] >= dsh) begin
                        r_rem[j+1][k] <= r_rem[j][k] - dsh;
                        r_quo[j+1][k] <= r_quo[j][k]
                                         | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
                    end else begin
                        r_rem[j+1][k] <= r_rem[j][k];
                        r_quo[j+1][k] <= r_quo[j][k];
                    end
                end
                r_drt[j+1] <= r_drt[j];
                r_dc[j+1]  <= r_dc[j];
            end
        end
    end

    always_comb begin
        logic [QUO_BITS-1:0] q [3];
        logic [OUT_BITS-1:0] res [3];
        for (int k = 0; k < 3; k++) begin
            q[k] = r_quo[QUO_BITS][k];
            if (q[k] > QUO_BITS'(OUT_ONE)) begin
                q[k] = QUO_BITS'(OUT_ONE);
            end
            res[k] = r_dc[QUO_BITS].neg[k] ? -OUT_BITS'(q[k]) : OUT_BITS'(q[k]);
            if (r_dc[QUO_BITS].zero) begin
                res[k] = '0;
            end
        end
        n_dir.dir_x = res[0];
        n_dir.dir_y = res[1];
        n_dir.dir_z = res[2];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dir <= n_dir;
        end
    end

endmodule
`default_nettype wire

[rtl/core/pinhole_primary_ray_direction.sv]
// ----------------------------------------------------------------------------
// Pinhole primary ray direction: top level.
// One transaction is accepted per cycle while o_stall is low; square root and divider are pipelined.
// The queue between front and back end holds QUEUE_DEPTH transactions.
// Reset is synchronous, active low, clears control state and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pinhole_primary_ray_direction_assert.svh"
module pinhole_primary_ray_direction #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  pprd_pkg::t_pixel                    i_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output pprd_pkg::t_dir                      o_dir,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pprd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [pprd_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [pprd_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import pprd_pkg::*;

    t_cfg        w_cfg;
    t_front_item w_front_item, w_back_item;
    logic        w_front_valid, w_full, w_push;
    logic        w_queue_valid, w_back_stall;

    assign w_push = w_front_valid && !w_full;

    pprd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pprd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (w_front_valid),
        .i_full  (w_full),
        .o_item  (w_front_item)
    );

    pprd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_full  (w_full),
        .i_item  (w_front_item),
        .o_valid (w_queue_valid),
        .i_stall (w_back_stall),
        .o_item  (w_back_item)
    );

    pprd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_queue_valid),
        .o_stall (w_back_stall),
        .i_item  (w_back_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_dir   (o_dir)
    );

    `PPRD_ASSERT_NOW(a_dir_range, i_clk, i_rst_n, o_valid, (o_dir.dir_x <= 16'sd16384) && (o_dir.dir_x >= -16'sd16384) && (o_dir.dir_y <= 16'sd16384) && (o_dir.dir_y >= -16'sd16384) && (o_dir.dir_z <= 16'sd16384) && (o_dir.dir_z >= -16'sd16384))
    `PPRD_ASSERT_NOW(a_back_holds, i_clk, i_rst_n, o_valid && i_stall, w_back_stall)
    `PPRD_ASSERT_NOW(a_full_after_push, i_clk, i_rst_n, $rose(w_full), $past(w_push))

endmodule
`default_nettype wire
